@@ src/assert_macros.svh @@
// Assertion macros, included by the top level to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pthc_pkg.sv @@
// Package with payload types and fixed-point constants of the hex cell index pipeline.
`timescale 1ns / 1ps

package pthc_pkg;

  localparam int unsigned POS_W     = 24;  // x and y, 8 fractional bits
  localparam int unsigned ID_W      = 10;  // stave and layer numbers
  localparam int unsigned PITCH_W   = 24;  // reciprocal pitch, 16 fractional bits
  localparam int unsigned INDEX_W   = 16;  // column and row of the result
  localparam int unsigned FRAC_BITS = 38;  // fraction bits of q, r and s

  // 1/sqrt(3) and 2/sqrt(3) with 30 fractional bits.
  localparam int unsigned ROOT_W = 31;
  localparam logic [ROOT_W-1:0] ONE_OVER_ROOT3 = 31'd619925131;
  localparam logic [ROOT_W-1:0] TWO_OVER_ROOT3 = 31'd1239850262;
  localparam int unsigned X_SHIFT = 30;

  localparam logic [PITCH_W-1:0] INV_PITCH_RESET = 24'd32768;

  // Datapath widths.
  localparam int unsigned SUM_W     = 55;              // mm terms, 2^-38 mm
  localparam int unsigned DROP_W    = 16;              // bits dropped before scaling
  localparam int unsigned SCALED_W  = SUM_W - DROP_W;  // mm terms, 2^-22 mm
  localparam int unsigned SPLIT_W   = 16;              // low part of the split multiply
  localparam int unsigned HI_W      = SCALED_W - SPLIT_W;
  localparam int unsigned HI_PROD_W = HI_W + PITCH_W + 1;
  localparam int unsigned LO_PROD_W = SPLIT_W + PITCH_W;
  localparam int unsigned FIX_W     = 64;              // q, r, s in 2^-38 cell
  localparam int unsigned RND_W     = 27;              // rounded cube coordinates
  localparam int unsigned ERR_W     = FRAC_BITS;       // rounding error magnitude
  localparam int unsigned DIFF_W    = FRAC_BITS + 2;   // signed rounding error
  localparam int unsigned CALC_W    = 29;              // offset conversion

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [ID_W-1:0]         stave;
    logic [ID_W-1:0]         layer;
  } in_req_t;

  typedef struct packed {
    logic signed [INDEX_W-1:0] column;
    logic signed [INDEX_W-1:0] row_index;
    logic                      is_cherenkov;
    logic [ID_W-1:0]           stave_out;
    logic [ID_W-1:0]           layer_out;
    logic                      saturated;
  } out_req_t;

  // Fractional axial coordinates leaving the scaling stages.
  typedef struct packed {
    logic signed [FIX_W-1:0] qf;
    logic signed [FIX_W-1:0] rf;
    logic [ID_W-1:0]         stave;
    logic [ID_W-1:0]         layer;
  } axial_t;

  // Rounded cube coordinates and their rounding errors.
  typedef struct packed {
    logic signed [RND_W-1:0] qi;
    logic signed [RND_W-1:0] ri;
    logic signed [RND_W-1:0] si;
    logic [ERR_W-1:0]        dq;
    logic [ERR_W-1:0]        dr;
    logic [ERR_W-1:0]        ds;
    logic [ID_W-1:0]         stave;
    logic [ID_W-1:0]         layer;
  } cube_t;

endpackage

@@ src/point_to_hex_cell_index_top.sv @@
// Top level of the point to hex cell index pipeline, with the pitch register.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall    in_req_t  (x_pos, y_pos, stave, layer)
//   out_      output     out_valid / out_stall  out_req_t (column, row_index, flags, ids)
//   cfg_      input      cfg_wr_en              cfg_wr_data (inv_cell_pitch)
//
// One request enters per clock while the input is not stalled, and its result passes
// through seven register stages: four for scaling (product, add, split multiply, merge),
// two for rounding and one for the offset conversion, which is the output register.
// Reset is synchronous and active low; it empties every stage and loads the pitch
// register with 0.5 cell per mm. A stall holds only the full stages behind it, so
// empty stages keep filling while a result waits at the output.
`timescale 1ns / 1ps

module point_to_hex_cell_index_top
  import pthc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [PITCH_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_req_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_req_t           out_data
);

  `include "assert_macros.svh"

  // Reciprocal cell pitch in cells per mm with 16 fractional bits. The user must
  // rewrite it only while the pipeline is empty, which the block does not enforce,
  // so stage three can read it directly.
  logic [PITCH_W-1:0] inv_cell_pitch_r;

  // Fractional axial coordinates between scaling and rounding.
  logic   ax_valid, ax_stall;
  axial_t ax_data;

  // Rounded cube coordinates between rounding and offset conversion.
  logic  cb_valid, cb_stall;
  cube_t cb_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_cell_pitch_r <= INV_PITCH_RESET;
    end else if (cfg_wr_en) begin
      inv_cell_pitch_r <= cfg_wr_data;
    end
  end

  // q = pitch * (x + y / sqrt(3)), r = pitch * 2y / sqrt(3), in 2^-38 cell.
  pthc_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .inv_cell_pitch (inv_cell_pitch_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (ax_valid),
    .out_stall      (ax_stall),
    .out_data       (ax_data)
  );

  // s = -q - r, then all three are rounded with halves away from zero.
  pthc_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ax_valid),
    .in_stall  (ax_stall),
    .in_data   (ax_data),
    .out_valid (cb_valid),
    .out_stall (cb_stall),
    .out_data  (cb_data)
  );

  // The worst rounded coordinate is rebuilt, then row = -r and the column
  // follows the odd-row offset layout. Both are clipped to the index range.
  pthc_offset u_offset (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cb_valid),
    .in_stall  (cb_stall),
    .in_data   (cb_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Reset empties the whole pipeline, the output stage included.
  `ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")

  // The input can only be held back by a stall at the output.
  `ASSERT_CLK(a_stall_source, in_stall |-> out_stall, "input stalled without output stall")

  // Without clipping, the fibre type is the parity of the delivered row.
  `ASSERT_CLK(a_fibre_parity,
    out_valid && !out_data.saturated |-> out_data.is_cherenkov == out_data.row_index[0],
    "fibre type does not match row parity")

endmodule

@@ src/pthc_scale.sv @@
// Four-stage scaling of the point into fractional axial hex coordinates.
`timescale 1ns / 1ps

module pthc_scale
  import pthc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PITCH_W-1:0]   inv_cell_pitch,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output axial_t               out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic s1, s2, s3, s4;

  logic signed [POS_W-1:0]     x1_r;
  logic signed [SUM_W-1:0]     yc1_r, yc_nxt;
  logic signed [SUM_W-1:0]     y2c1_r, y2c_nxt;
  logic [ID_W-1:0]             st1_r, ly1_r, st2_r, ly2_r, st3_r, ly3_r;

  logic signed [SUM_W-1:0]     qsum;
  logic signed [SCALED_W-1:0]  qs2_r, rs2_r;

  logic signed [PITCH_W:0]     pitch_s;
  logic signed [HI_PROD_W-1:0] qh3_r, rh3_r, qh_nxt, rh_nxt;
  logic [LO_PROD_W-1:0]        ql3_r, rl3_r, ql_nxt, rl_nxt;

  axial_t                      ax4_r, ax_nxt;

  // A stage holds while it is full and the stage after it holds.
  assign s4       = v4_r && out_stall;
  assign s3       = v3_r && s4;
  assign s2       = v2_r && s3;
  assign s1       = v1_r && s2;
  assign in_stall = s1;

  assign yc_nxt  = SUM_W'(in_data.y_pos * $signed({1'b0, ONE_OVER_ROOT3}));
  assign y2c_nxt = SUM_W'(in_data.y_pos * $signed({1'b0, TWO_OVER_ROOT3}));

  // Dropping the low bits of a signed word rounds toward minus infinity.
  assign qsum = (SUM_W'(x1_r) <<< X_SHIFT) + yc1_r;

  // The scaled terms are split so that each product stays narrow.
  assign pitch_s = $signed({1'b0, inv_cell_pitch});
  assign qh_nxt  = HI_PROD_W'($signed(qs2_r[SCALED_W-1:SPLIT_W]) * pitch_s);
  assign rh_nxt  = HI_PROD_W'($signed(rs2_r[SCALED_W-1:SPLIT_W]) * pitch_s);
  assign ql_nxt  = LO_PROD_W'(qs2_r[SPLIT_W-1:0] * inv_cell_pitch);
  assign rl_nxt  = LO_PROD_W'(rs2_r[SPLIT_W-1:0] * inv_cell_pitch);

  always_comb begin
    ax_nxt       = ax4_r;
    ax_nxt.qf    = (FIX_W'(qh3_r) <<< SPLIT_W) + FIX_W'(ql3_r);
    ax_nxt.rf    = (FIX_W'(rh3_r) <<< SPLIT_W) + FIX_W'(rl3_r);
    ax_nxt.stave = st3_r;
    ax_nxt.layer = ly3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (!s1) v1_r <= in_valid;
      if (!s2) v2_r <= v1_r;
      if (!s3) v3_r <= v2_r;
      if (!s4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1) begin
      x1_r   <= in_data.x_pos;
      yc1_r  <= yc_nxt;
      y2c1_r <= y2c_nxt;
      st1_r  <= in_data.stave;
      ly1_r  <= in_data.layer;
    end
    if (!s2) begin
      qs2_r <= qsum[SUM_W-1:DROP_W];
      rs2_r <= y2c1_r[SUM_W-1:DROP_W];
      st2_r <= st1_r;
      ly2_r <= ly1_r;
    end
    if (!s3) begin
      qh3_r <= qh_nxt;
      rh3_r <= rh_nxt;
      ql3_r <= ql_nxt;
      rl3_r <= rl_nxt;
      st3_r <= st2_r;
      ly3_r <= ly2_r;
    end
    if (!s4) begin
      ax4_r <= ax_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = ax4_r;

endmodule

@@ src/pthc_round.sv @@
// Two-stage rounding of q, r and s to the nearest integer, with rounding errors.
`timescale 1ns / 1ps

module pthc_round
  import pthc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  axial_t in_data,
  output logic   out_valid,
  input  logic   out_stall,
  output cube_t  out_data
);

  localparam logic [FIX_W-1:0] HALF = FIX_W'(1) << (FRAC_BITS - 1);

  logic v5_r, v6_r;
  logic s5, s6;

  logic signed [FIX_W-1:0] qf5_r, rf5_r, sf5_r;
  logic [ID_W-1:0]         st5_r, ly5_r;
  cube_t                   cb6_r, cb_nxt;

  // Nearest integer with halves going away from zero.
  function automatic logic signed [RND_W-1:0] round_away(input logic signed [FIX_W-1:0] v);
    logic [FIX_W-1:0] m;
    logic [FIX_W-1:0] n;
    m = v[FIX_W-1] ? FIX_W'(-v) : FIX_W'(v);
    n = (m + HALF) >> FRAC_BITS;
    round_away = v[FIX_W-1] ? -$signed(n[RND_W-1:0]) : $signed(n[RND_W-1:0]);
  endfunction

  // The error never exceeds half a cell, so the low bits of the difference suffice.
  function automatic logic [ERR_W-1:0] round_err(input logic signed [RND_W-1:0] vi,
                                                 input logic signed [FIX_W-1:0] vf);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] m;
    d = {vi[DIFF_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} - vf[DIFF_W-1:0];
    m = d[DIFF_W-1] ? -d : d;
    round_err = m[ERR_W-1:0];
  endfunction

  assign s6       = v6_r && out_stall;
  assign s5       = v5_r && s6;
  assign in_stall = s5;

  always_comb begin
    cb_nxt       = cb6_r;
    cb_nxt.qi    = round_away(qf5_r);
    cb_nxt.ri    = round_away(rf5_r);
    cb_nxt.si    = round_away(sf5_r);
    cb_nxt.dq    = round_err(cb_nxt.qi, qf5_r);
    cb_nxt.dr    = round_err(cb_nxt.ri, rf5_r);
    cb_nxt.ds    = round_err(cb_nxt.si, sf5_r);
    cb_nxt.stave = st5_r;
    cb_nxt.layer = ly5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (!s5) v5_r <= in_valid;
      if (!s6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s5) begin
      qf5_r <= in_data.qf;
      rf5_r <= in_data.rf;
      sf5_r <= -in_data.qf - in_data.rf;
      st5_r <= in_data.stave;
      ly5_r <= in_data.layer;
    end
    if (!s6) begin
      cb6_r <= cb_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = cb6_r;

endmodule

@@ src/pthc_offset.sv @@
// Cube rounding fix-up, odd-row offset conversion and clipping into the output register.
`timescale 1ns / 1ps

module pthc_offset
  import pthc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cube_t    in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam logic signed [CALC_W-1:0] IDX_MAX = CALC_W'((1 << (INDEX_W - 1)) - 1);
  localparam logic signed [CALC_W-1:0] IDX_MIN = -IDX_MAX - CALC_W'(1);

  logic                     out_valid_r;
  out_req_t                 out_data_r, out_nxt;
  logic signed [CALC_W-1:0] q_sel, r_sel, row, row_even, col;
  logic                     col_hi, col_lo, row_hi, row_lo;

  always_comb begin
    q_sel = CALC_W'(in_data.qi);
    r_sel = CALC_W'(in_data.ri);
    // Rebuild the coordinate that rounded worst from the other two.
    if (in_data.dq > in_data.dr && in_data.dq > in_data.ds) begin
      q_sel = -CALC_W'(in_data.ri) - CALC_W'(in_data.si);
    end else if (in_data.dr > in_data.ds) begin
      r_sel = -CALC_W'(in_data.qi) - CALC_W'(in_data.si);
    end
    row      = -r_sel;
    row_even = row + CALC_W'(row[0]);
    col      = q_sel - (row_even >>> 1);

    col_hi = col > IDX_MAX;
    col_lo = col < IDX_MIN;
    row_hi = row > IDX_MAX;
    row_lo = row < IDX_MIN;

    out_nxt.column       = col_hi ? IDX_MAX[INDEX_W-1:0] :
                           col_lo ? IDX_MIN[INDEX_W-1:0] : col[INDEX_W-1:0];
    out_nxt.row_index    = row_hi ? IDX_MAX[INDEX_W-1:0] :
                           row_lo ? IDX_MIN[INDEX_W-1:0] : row[INDEX_W-1:0];
    out_nxt.is_cherenkov = row[0];
    out_nxt.stave_out    = in_data.stave;
    out_nxt.layer_out    = in_data.layer;
    out_nxt.saturated    = col_hi | col_lo | row_hi | row_lo;
  end

  assign in_stall = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/point_to_hex_cell_index_top_tb.sv @@
// Self-checking testbench of the point to hex cell index pipeline, with its own cell predictor.
`timescale 1ns / 1ps

module point_to_hex_cell_index_top_tb
  import pthc_pkg::*;
;

  // 1/sqrt(3) with 30 fractional bits, one cell with 38 fractional bits, and half a cell.
  localparam longint INV_ROOT3 = 64'sd619925131;
  localparam longint CELL_ONE  = 64'sd274877906944;
  localparam longint CELL_HALF = 64'sd137438953472;

  // Range of a 16-bit signed column or row.
  localparam longint IDX_MAX = 64'sd32767;
  localparam longint IDX_MIN = -64'sd32768;

  localparam int PHASES       = 7;
  localparam int PHASE_POINTS = 150;
  localparam int LONG_HOLD    = 80;    // receiver back-pressure that fills the pipeline
  localparam int DRAIN_WAIT   = 12;    // idle wait after the last drain, before the verdict
  localparam int STUCK_LIMIT  = 3000;  // cycles without any request moving

  localparam int X_MAX = 8388607;
  localparam int X_MIN = -8388608;

  // Holds the pitch register copy, predicts the cell of every accepted point and
  // checks the results in order.
  class hex_cell_scoreboard;
    out_req_t          cells_due[$];
    logic [PITCH_W-1:0] pitch;
    int                errors;

    function new();
      pitch  = INV_PITCH_RESET;
      errors = 0;
    endfunction

    function void set_pitch(logic [PITCH_W-1:0] value);
      pitch = value;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Nearest integer of a 38-bit fraction, halves rounded away from zero.
    function longint nearest_int(longint v);
      longint n;
      n = (magnitude(v) + CELL_HALF) >>> 38;
      return (v < 0) ? -n : n;
    endfunction

    function longint clip_index(longint v);
      if (v > IDX_MAX) return IDX_MAX;
      if (v < IDX_MIN) return IDX_MIN;
      return v;
    endfunction

    function out_req_t locate_cell(in_req_t pt);
      longint   x, y, pv, qf, rf, sf, qi, ri, si, dq, dr, ds, row, col, cc, rc;
      out_req_t res;
      x  = longint'(pt.x_pos);
      y  = longint'(pt.y_pos);
      pv = longint'(pitch);
      // Scale to axial coordinates; the arithmetic shift floors toward minus infinity.
      qf = (((x <<< 30) + y * INV_ROOT3) >>> 16) * pv;
      rf = ((y * (2 * INV_ROOT3)) >>> 16) * pv;
      sf = -qf - rf;
      qi = nearest_int(qf);
      ri = nearest_int(rf);
      si = nearest_int(sf);
      dq = magnitude(qi * CELL_ONE - qf);
      dr = magnitude(ri * CELL_ONE - rf);
      ds = magnitude(si * CELL_ONE - sf);
      // Rebuild the coordinate that was rounded worst; a tie goes to the later of q, r, s.
      if (dq > dr && dq > ds) begin
        qi = -ri - si;
      end else if (dr > ds) begin
        ri = -qi - si;
      end
      row = -ri;
      col = qi - (row + (row & 64'sd1)) / 2;
      cc  = clip_index(col);
      rc  = clip_index(row);
      res.column       = cc[INDEX_W-1:0];
      res.row_index    = rc[INDEX_W-1:0];
      res.is_cherenkov = row[0];
      res.stave_out    = pt.stave;
      res.layer_out    = pt.layer;
      res.saturated    = (cc != col) || (rc != row);
      return res;
    endfunction

    function void note_point(in_req_t pt);
      cells_due.push_back(locate_cell(pt));
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_cell(out_req_t got);
      out_req_t want;
      if (cells_due.size() == 0) begin
        $display("%0t ns: unexpected result, column %0d row %0d", $time,
                 $signed(got.column), $signed(got.row_index));
        errors++;
        return;
      end
      want = cells_due.pop_front();
      compare_field("column", 64'($signed(want.column)), 64'($signed(got.column)));
      compare_field("row_index", 64'($signed(want.row_index)),
                    64'($signed(got.row_index)));
      compare_field("is_cherenkov", 64'(want.is_cherenkov), 64'(got.is_cherenkov));
      compare_field("stave_out", 64'(want.stave_out), 64'(got.stave_out));
      compare_field("layer_out", 64'(want.layer_out), 64'(got.layer_out));
      compare_field("saturated", 64'(want.saturated), 64'(got.saturated));
    endfunction
  endclass

  // Every input of the block has a known value from time zero.
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [PITCH_W-1:0] cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  in_req_t            in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  out_req_t           out_data;

  hex_cell_scoreboard cell_board;

  // Shared between the sender and the receiver. While steady is set neither side
  // idles; hold_results asks the receiver for one long stretch of back-pressure.
  bit steady       = 1'b0;
  bit hold_results = 1'b0;

  point_to_hex_cell_index_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Half of the draws give no pause outright; the other half draw a random pause, which can also be none.
  function automatic int idle_cycles();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic in_req_t make_point(int x, int y, int st, int ly);
    in_req_t pt;
    pt.x_pos = x[POS_W-1:0];
    pt.y_pos = y[POS_W-1:0];
    pt.stave = st[ID_W-1:0];
    pt.layer = ly[ID_W-1:0];
    return pt;
  endfunction

  // A quarter of the points use the full position range, half use a random width so
  // that small and unsaturated cells are common, and the rest lie on a whole-mm grid
  // in x, where power-of-two pitches give exact half-cell ties.
  function automatic in_req_t random_point();
    in_req_t            pt;
    logic signed [31:0] a;
    logic signed [31:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 3))
      0: begin
      end
      1, 2: begin
        a = a >>> (32 - $urandom_range(1, 24));
        b = b >>> (32 - $urandom_range(1, 24));
      end
      default: begin
        a = (a >>> 20) * 256;
        b = ($urandom_range(0, 1) == 0) ? 32'sd0 : (b >>> 20) * 128;
      end
    endcase
    pt.x_pos = a[POS_W-1:0];
    pt.y_pos = b[POS_W-1:0];
    pt.stave = ID_W'($urandom_range(0, 1023));
    pt.layer = ID_W'($urandom_range(0, 1023));
    return pt;
  endfunction

  // Offers one request after its idle gap and returns at the edge that takes it.
  // Valid stays high when the next request follows without a gap.
  task automatic send_point(input in_req_t pt);
    int gap;
    gap = steady ? 0 : idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cell_board.note_point(pt);
  endtask

  // Stops offering and waits until every predicted cell has come back. Every point
  // gives a result, so nothing is still in flight after that.
  task automatic drain_points();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cell_board.cells_due.size() != 0) @(posedge clk);
  endtask

  // Writes the pitch register; only called while the pipeline is empty.
  task automatic write_pitch(input logic [PITCH_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cell_board.set_pitch(value);
  endtask

  // Main sequence: reset, a directed part at four pitches, then random phases that
  // each start from an empty pipeline with a fresh pitch.
  initial begin
    logic [PITCH_W-1:0] pitch_pick;
    cell_board = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset pitch of 0.5 cell per mm: origin, exact half-cell ties in both signs
    // (q and s tie on their error, so nothing is rebuilt), whole cells, the
    // smallest offsets around zero, and the corners of the position range.
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(256, 0, 1023, 1023));
    send_point(make_point(-256, 0, 0, 1023));
    send_point(make_point(512, 0, 1023, 0));
    send_point(make_point(1, -1, 512, 511));
    send_point(make_point(-1, 1, 341, 682));
    send_point(make_point(X_MAX, X_MAX, 1023, 1023));
    send_point(make_point(X_MIN, X_MIN, 0, 0));
    send_point(make_point(X_MAX, X_MIN, 1, 2));
    send_point(make_point(X_MIN, X_MAX, 3, 4));
    send_point(make_point(0, X_MAX, 5, 6));
    send_point(make_point(0, X_MIN, 7, 8));
    drain_points();

    // A pitch of zero maps every point to the origin cell.
    write_pitch('0);
    send_point(make_point(X_MAX, X_MIN, 1023, 0));
    send_point(make_point(123456, -7654, 0, 1023));
    drain_points();

    // The largest pitch clips column and row in both directions; the fibre type
    // still follows the unclipped row.
    write_pitch('1);
    send_point(make_point(X_MAX, X_MAX, 10, 20));
    send_point(make_point(X_MIN, X_MIN, 30, 40));
    send_point(make_point(X_MAX, 0, 50, 60));
    send_point(make_point(0, X_MIN, 70, 80));
    send_point(make_point(256, 256, 90, 100));
    drain_points();

    // The smallest pitch keeps even the extreme points near the origin.
    write_pitch(24'd1);
    send_point(make_point(X_MAX, X_MAX, 11, 22));
    send_point(make_point(-1, -1, 33, 44));
    drain_points();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: pitch_pick = INV_PITCH_RESET;
        1: pitch_pick = '1;
        2: pitch_pick = 24'd1;
        4: pitch_pick = PITCH_W'($urandom_range(1, 65535));
        5: pitch_pick = PITCH_W'($urandom >> $urandom_range(8, 31));
        default: pitch_pick = PITCH_W'($urandom);
      endcase
      write_pitch(pitch_pick);
      // The first phase sends back to back while the receiver holds off, so the
      // pipeline fills and stalls its input; another phase runs with no idling.
      steady       = (ph == 0) || (ph == 4);
      hold_results = (ph == 0);
      for (int i = 0; i < PHASE_POINTS; i++) begin
        send_point(random_point());
      end
      // The sender pauses here until every expected cell has come back.
      drain_points();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (cell_board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: before each result it draws a stall, or takes the long hold when one
  // is asked for, and then accepts the next result that shows up.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        gap          = LONG_HOLD;
        hold_results = 1'b0;
      end else begin
        gap = steady ? 0 : idle_cycles();
      end
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      cell_board.check_cell(out_data);
    end
  end

  // Watchdog: ends the run when no request has moved on either channel for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("%0t ns: timeout, no request moved for %0d cycles", $time, STUCK_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/pthc_pkg.sv
src/pthc_scale.sv
src/pthc_round.sv
src/pthc_offset.sv
src/point_to_hex_cell_index_top.sv
tb/sv/point_to_hex_cell_index_top_tb.sv
